// ----- rtl/isa_pkg.sv -----
`timescale 1ns / 1ps
package isa_pkg;

    typedef enum logic [1:0] {
        FUNC_TAS  = 2'd0,
        FUNC_IAS  = 2'd1,
        FUNC_SINK = 2'd2,
        FUNC_NONE = 2'd3
    } isa_func_t;

    localparam int FRAC_BITS_DEF = 4;
    localparam int SPD_W         = 14;
    localparam int OUT_W         = 16;
    localparam int GLIDE_W       = 6;
    localparam logic [GLIDE_W-1:0] GLIDE_RESET = 6'd15;

    localparam int T0_X2000    = 576300;
    localparam int LAPSE_X2000 = 13;
    localparam int DEV_X2000   = 2000;
    localparam int TROPO_TOP   = 11000;

    localparam logic [26:0] EXPO_Q24  = 27'd88179913;
    localparam logic [27:0] STRAT_Q40 = 28'd250137490;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [14:0] SINK_NUM  = 15'd19686;
    localparam int SINK_DEN  = 100;
    localparam int SINK_HALF = 50;

    localparam int LG_IN_W = 21;
    localparam int LG_N_W  = 5;
    localparam int LG_FRAC = 24;
    localparam int LG_W    = LG_N_W + LG_FRAC;
    localparam int STRAT_W = 27;
    localparam int FR_W    = 24;
    localparam int IP_W    = 4;
    localparam int E_W     = 31;
    localparam int EXP_TERMS = 12;

    typedef struct packed {
        isa_func_t          func;
        logic [SPD_W-1:0]   spd;
        logic [STRAT_W-1:0] strat;
    } isa_lside_t;

    typedef struct packed {
        isa_func_t         func;
        logic [SPD_W-1:0]  spd;
        logic [IP_W-1:0]   ip;
    } isa_eside_t;

    function automatic logic [LG_W-1:0] lg2_q24_const(input logic [31:0] x);
        logic [LG_N_W-1:0] n;
        logic [63:0]       m;
        logic [LG_FRAC-1:0] frac;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                n = LG_N_W'(i);
            end
        end
        if (n == 5'd31) begin
            m = 64'(x >> 1);
        end else begin
            m = 64'(x) << (30 - int'(n));
        end
        frac = '0;
        for (int i = LG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return {n, frac};
    endfunction

    localparam logic [LG_W-1:0] LG0 = lg2_q24_const(32'(T0_X2000));

    function automatic logic [31:0] exp_recip(input int k);
        logic [31:0] r;
        case (k)
            3:       r = 32'd1431655765;
            5:       r = 32'd858993459;
            6:       r = 32'd715827882;
            7:       r = 32'd613566756;
            9:       r = 32'd477218588;
            10:      r = 32'd429496729;
            11:      r = 32'd390451572;
            12:      r = 32'd357913941;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic int exp_shift(input int k);
        int s;
        case (k)
            2:       s = 1;
            4:       s = 2;
            8:       s = 3;
            default: s = 0;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/isa_lg2.sv -----
`timescale 1ns / 1ps
module isa_lg2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [isa_pkg::LG_IN_W-1:0]   in_x [2],
    input  isa_pkg::isa_lside_t           in_side,
    output logic                          out_valid,
    output logic [isa_pkg::LG_W-1:0]      out_lg [2],
    output isa_pkg::isa_lside_t           out_side
);
    import isa_pkg::*;

    localparam int STAGES = LG_FRAC;

    logic [30:0]         m_reg [0:STAGES][2];
    logic [LG_N_W-1:0]   n_reg [0:STAGES][2];
    logic [LG_FRAC-1:0]  f_reg [0:STAGES][2];
    logic                valid_reg [0:STAGES];
    isa_lside_t          side_reg [0:STAGES];

    logic [LG_N_W-1:0]   n_next [2];
    logic [30:0]         m_next [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            n_next[l] = '0;
            for (int b = 0; b < LG_IN_W; b++)
            begin
                if (in_x[l][b])
                begin
                    n_next[l] = LG_N_W'(b);
                end
            end
            m_next[l] = 31'({{(31 - LG_IN_W){1'b0}}, in_x[l]} << (5'd30 - n_next[l]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            m_reg[0][l] <= m_next[l];
            n_reg[0][l] <= n_next[l];
            f_reg[0][l] <= '0;
        end
        side_reg[0] <= in_side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    for (genvar s = 1; s <= STAGES; s++)
    begin : g_sq
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [61:0] prod;
            logic [31:0] sq;
            logic [30:0] sq_next;
            assign prod    = 62'(m_reg[s-1][l]) * 62'(m_reg[s-1][l]);
            assign sq      = prod[61:30];
            assign sq_next = sq[31] ? sq[31:1] : sq[30:0];

            always_ff @(posedge clk)
            begin
                m_reg[s][l] <= sq_next;
                n_reg[s][l] <= n_reg[s-1][l];
                f_reg[s][l] <= {f_reg[s-1][l][LG_FRAC-2:0], sq[31]};
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[s] <= side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_side  = side_reg[STAGES];
    assign out_lg[0] = {n_reg[STAGES][0], f_reg[STAGES][0]};
    assign out_lg[1] = {n_reg[STAGES][1], f_reg[STAGES][1]};

endmodule

// ----- rtl/isa_vcalc.sv -----
`timescale 1ns / 1ps
module isa_vcalc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [isa_pkg::LG_W-1:0]  in_lg [2],
    input  isa_pkg::isa_lside_t       in_side,
    output logic                      out_valid,
    output logic [isa_pkg::FR_W-1:0]  out_fr,
    output isa_pkg::isa_eside_t       out_side
);
    import isa_pkg::*;

    localparam logic signed [35:0] V_LIM = 36'sd134217728;

    logic [55:0]       dprod_reg;
    logic [LG_W-1:0]   lgt_reg;
    isa_lside_t        c1_side_reg;
    logic              c1_valid_reg;
    logic [FR_W-1:0]   fr_reg;
    isa_eside_t        c2_side_reg;
    logic              c2_valid_reg;

    logic [55:0]       dprod_next;
    logic [32:0]       p_val;
    logic signed [35:0] s_val;
    logic signed [35:0] s_adj;
    logic signed [35:0] v_half;
    logic signed [35:0] v_neg;
    logic signed [35:0] v_clip;
    logic signed [35:0] u_val;

    assign dprod_next = 56'(EXPO_Q24) * 56'(LG0 - in_lg[1]);

    always_comb
    begin
        p_val  = 33'(dprod_reg[55:24]) + 33'(c1_side_reg.strat);
        s_val  = signed'(36'(p_val)) + signed'(36'(lgt_reg)) - signed'(36'(LG0));
        s_adj  = s_val + signed'({35'b0, s_val[35]});
        v_half = s_adj >>> 1;
        v_neg  = (c1_side_reg.func == FUNC_IAS) ? -v_half : v_half;
        if (v_neg < -V_LIM)
        begin
            v_clip = -V_LIM;
        end
        else if (v_neg > V_LIM - 36'sd1)
        begin
            v_clip = V_LIM - 36'sd1;
        end
        else
        begin
            v_clip = v_neg;
        end
        u_val = v_clip + V_LIM;
    end

    always_ff @(posedge clk)
    begin
        dprod_reg        <= dprod_next;
        lgt_reg          <= in_lg[0];
        c1_side_reg      <= in_side;
        fr_reg           <= u_val[FR_W-1:0];
        c2_side_reg.func <= c1_side_reg.func;
        c2_side_reg.spd  <= c1_side_reg.spd;
        c2_side_reg.ip   <= u_val[FR_W+IP_W-1:FR_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else
        begin
            c1_valid_reg <= in_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    assign out_valid = c2_valid_reg;
    assign out_fr    = fr_reg;
    assign out_side  = c2_side_reg;

endmodule

// ----- rtl/isa_exp2.sv -----
`timescale 1ns / 1ps
module isa_exp2 (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [isa_pkg::FR_W-1:0]  in_fr,
    input  isa_pkg::isa_eside_t       in_side,
    output logic                      out_valid,
    output logic [isa_pkg::E_W-1:0]   out_e,
    output isa_pkg::isa_eside_t       out_side
);
    import isa_pkg::*;

    localparam int STAGES = 3 * EXP_TERMS;

    typedef struct packed {
        logic [29:0]    y;
        logic [E_W-1:0] sum;
        logic [E_W-1:0] term;
        logic [E_W-1:0] q;
        isa_eside_t     side;
    } isa_estage_t;

    isa_estage_t st_reg [0:STAGES];
    logic        valid_reg [0:STAGES];

    logic [53:0] y_prod;
    isa_estage_t st0_next;

    assign y_prod = 54'(in_fr) * 54'(LN2_Q30);

    always_comb
    begin
        st0_next.y    = y_prod[53:24];
        st0_next.sum  = E_W'(1) << 30;
        st0_next.term = E_W'(1) << 30;
        st0_next.q    = '0;
        st0_next.side = in_side;
    end

    always_ff @(posedge clk)
    begin
        st_reg[0] <= st0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    for (genvar s = 1; s <= STAGES; s++)
    begin : g_valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    for (genvar k = 1; k <= EXP_TERMS; k++)
    begin : g_term
        localparam int          J  = 3 * k - 2;
        localparam logic [31:0] RC = exp_recip(k);
        localparam int          SH = exp_shift(k);
        localparam logic [34:0] KV = 35'(k);

        logic [60:0] t_prod;
        isa_estage_t a_next;
        isa_estage_t b_next;
        isa_estage_t c_next;

        assign t_prod = 61'(st_reg[J-1].term) * 61'(st_reg[J-1].y);

        always_comb
        begin
            a_next      = st_reg[J-1];
            a_next.term = t_prod[60:30];
        end

        if (RC == 32'd0)
        begin : g_shift
            always_comb
            begin
                b_next   = st_reg[J];
                b_next.q = st_reg[J].term >> SH;
            end

            always_comb
            begin
                c_next      = st_reg[J+1];
                c_next.term = st_reg[J+1].q;
                c_next.sum  = st_reg[J+1].sum + st_reg[J+1].q;
            end
        end
        else
        begin : g_recip
            logic [62:0] r_prod;
            logic [34:0] r_val;
            logic [E_W-1:0] q_fix;

            assign r_prod = 63'(st_reg[J].term) * 63'(RC);

            always_comb
            begin
                b_next   = st_reg[J];
                b_next.q = r_prod[62:32];
            end

            always_comb
            begin
                r_val = 35'(st_reg[J+1].term) - 35'(st_reg[J+1].q) * KV;
                q_fix = (r_val >= KV) ? st_reg[J+1].q + E_W'(1) : st_reg[J+1].q;
                c_next      = st_reg[J+1];
                c_next.term = q_fix;
                c_next.sum  = st_reg[J+1].sum + q_fix;
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[J]   <= a_next;
            st_reg[J+1] <= b_next;
            st_reg[J+2] <= c_next;
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_e     = st_reg[STAGES].sum;
    assign out_side  = st_reg[STAGES].side;

endmodule

// ----- rtl/isa_out.sv -----
`timescale 1ns / 1ps
module isa_out #(
    parameter int FRAC_BITS = isa_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [isa_pkg::E_W-1:0]      in_e,
    input  isa_pkg::isa_eside_t          in_side,
    input  logic [isa_pkg::GLIDE_W-1:0]  glide_ratio,
    output logic                         out_valid,
    output logic [isa_pkg::OUT_W-1:0]    out_speed,
    output logic                         out_sat
);
    import isa_pkg::*;

    localparam int XW  = SPD_W + E_W;
    localparam int XSW = XW + (1 << IP_W) - 1;
    localparam int TW  = XSW - 22;
    localparam int PW  = TW + 15;
    localparam int SH  = 16 + FRAC_BITS;
    localparam int AW  = PW - SH;
    localparam int DW  = 13;
    localparam int QW  = OUT_W;
    localparam int CW  = (AW + 1 > DW + QW) ? AW + 1 : DW + QW;

    typedef struct packed {
        isa_func_t       func;
        logic [22:0]     rnd;
        logic            ovf;
        logic [DW-1:0]   d;
        logic [DW-1:0]   rem;
        logic [QW-1:0]   low;
        logic [QW-1:0]   q;
    } isa_dstage_t;

    logic [XW-1:0]   x_reg;
    isa_eside_t      f1_side_reg;
    logic [XSW-1:0]  xs_reg;
    isa_func_t       f2_func_reg;
    logic [22:0]     rnd_reg;
    logic [PW-1:0]   sp_reg;
    isa_func_t       f3_func_reg;
    logic [2:0]      fv_reg;
    isa_dstage_t     dv_reg [0:QW];
    logic            dvalid_reg [0:QW];
    logic            done_reg;
    logic [OUT_W-1:0] speed_reg;
    logic            sat_reg;

    logic [XSW:0]    rnd_sum;
    logic [CW-1:0]   n_val;
    logic [DW-1:0]   d_val;
    logic [11:0]     half_val;
    isa_dstage_t     dv0_next;
    logic [OUT_W-1:0] speed_next;
    logic            sat_next;

    assign rnd_sum  = (XSW+1)'(xs_reg) + ((XSW+1)'(1) << 37);
    assign d_val    = DW'(glide_ratio) * DW'(SINK_DEN);
    assign half_val = 12'(glide_ratio) * 12'(SINK_HALF);
    assign n_val    = CW'(sp_reg >> SH) + CW'(half_val);

    always_comb
    begin
        dv0_next.func = f3_func_reg;
        dv0_next.rnd  = rnd_reg;
        dv0_next.ovf  = n_val >= CW'({d_val, {QW{1'b0}}});
        dv0_next.d    = d_val;
        dv0_next.rem  = n_val[DW+QW-1:QW];
        dv0_next.low  = n_val[QW-1:0];
        dv0_next.q    = '0;
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= XW'(in_side.spd) * XW'(in_e);
        f1_side_reg <= in_side;
        xs_reg      <= XSW'(x_reg) << f1_side_reg.ip;
        f2_func_reg <= f1_side_reg.func;
        rnd_reg     <= rnd_sum[XSW:38];
        sp_reg      <= PW'(xs_reg[XSW-1:22]) * PW'(SINK_NUM);
        f3_func_reg <= f2_func_reg;
        dv_reg[0]   <= dv0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg        <= '0;
            dvalid_reg[0] <= 1'b0;
        end
        else
        begin
            fv_reg        <= {fv_reg[1:0], in_valid};
            dvalid_reg[0] <= fv_reg[2];
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_div
        logic [DW:0]   t_val;
        logic          ge;
        logic [DW:0]   t_sub;
        isa_dstage_t   dv_next;

        always_comb
        begin
            t_val   = {dv_reg[s-1].rem, dv_reg[s-1].low[QW-1]};
            ge      = t_val >= {1'b0, dv_reg[s-1].d};
            t_sub   = ge ? t_val - {1'b0, dv_reg[s-1].d} : t_val;
            dv_next     = dv_reg[s-1];
            dv_next.rem = t_sub[DW-1:0];
            dv_next.low = {dv_reg[s-1].low[QW-2:0], 1'b0};
            dv_next.q   = {dv_reg[s-1].q[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            dv_reg[s] <= dv_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dvalid_reg[s] <= 1'b0;
            end
            else
            begin
                dvalid_reg[s] <= dvalid_reg[s-1];
            end
        end
    end

    always_comb
    begin
        case (dv_reg[QW].func)
            FUNC_TAS, FUNC_IAS:
            begin
                sat_next   = dv_reg[QW].rnd[22:16] != '0;
                speed_next = sat_next ? '1 : dv_reg[QW].rnd[15:0];
            end
            FUNC_SINK:
            begin
                sat_next   = dv_reg[QW].ovf;
                speed_next = sat_next ? '1 : dv_reg[QW].q;
            end
            default:
            begin
                sat_next   = 1'b0;
                speed_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
        sat_reg   <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dvalid_reg[QW];
        end
    end

    assign out_valid = done_reg;
    assign out_speed = speed_reg;
    assign out_sat   = sat_reg;

endmodule

// ----- rtl/isa_airspeed_converter_top.sv -----
`timescale 1ns / 1ps
// Air data converter: a conversion accepted on start appears on speed_out
// and saturated, marked by done, and a new conversion may be started in
// every cycle, so busy stays low. The datapath includes the two 24-step
// logarithm pipelines, the 12-term exponential series (three stages per
// term) and the 16-step sink rate divider. The receiver cannot stall; each
// result is shown for one cycle only. The glide ratio may be changed only
// while no conversion is in flight.
module isa_airspeed_converter_top #(
    parameter int FRAC_BITS = isa_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic [isa_pkg::SPD_W-1:0]     speed_in,
    input  logic signed [15:0]            altitude_m,
    input  logic signed [6:0]             temp_deviation,
    output logic                          done,
    output logic [isa_pkg::OUT_W-1:0]     speed_out,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [isa_pkg::GLIDE_W-1:0]   cfg_data
);
    import isa_pkg::*;

    logic [GLIDE_W-1:0]  glide_reg;
    logic                s0_valid_reg;
    isa_func_t           s0_func_reg;
    logic [SPD_W-1:0]    s0_spd_reg;
    logic signed [15:0]  s0_alt_reg;
    logic signed [6:0]   s0_dev_reg;
    logic                s1_valid_reg;
    logic [LG_IN_W-1:0]  s1_x_reg [2];
    isa_lside_t          s1_side_reg;

    logic signed [22:0]  tk_val;
    logic [14:0]         ap_val;
    logic [14:0]         trop_val;
    logic [14:0]         sdiff_val;
    logic [LG_IN_W-1:0]  tv_val;
    logic [42:0]         sprod;

    logic                lg_valid;
    logic [LG_W-1:0]     lg_out [2];
    isa_lside_t          lg_side;
    logic                vc_valid;
    logic [FR_W-1:0]     vc_fr;
    isa_eside_t          vc_side;
    logic                ex_valid;
    logic [E_W-1:0]      ex_e;
    isa_eside_t          ex_side;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_reg <= GLIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            glide_reg <= cfg_data;
        end
    end

    always_comb
    begin
        tk_val    = 23'(T0_X2000) - 23'(LAPSE_X2000) * 23'(s0_alt_reg)
                    + 23'(DEV_X2000) * 23'(s0_dev_reg);
        ap_val    = s0_alt_reg[15] ? 15'd0 : s0_alt_reg[14:0];
        trop_val  = (ap_val > 15'(TROPO_TOP)) ? 15'(TROPO_TOP) : ap_val;
        sdiff_val = (ap_val > 15'(TROPO_TOP)) ? ap_val - 15'(TROPO_TOP) : 15'd0;
        tv_val    = LG_IN_W'(T0_X2000) - LG_IN_W'(LAPSE_X2000) * LG_IN_W'(trop_val);
        sprod     = 43'(STRAT_Q40) * 43'(sdiff_val);
    end

    always_ff @(posedge clk)
    begin
        s0_func_reg       <= isa_func_t'(func);
        s0_spd_reg        <= speed_in;
        s0_alt_reg        <= altitude_m;
        s0_dev_reg        <= temp_deviation;
        s1_x_reg[0]       <= tk_val[LG_IN_W-1:0];
        s1_x_reg[1]       <= tv_val;
        s1_side_reg.func  <= s0_func_reg;
        s1_side_reg.spd   <= s0_spd_reg;
        s1_side_reg.strat <= sprod[42:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    isa_lg2 u_lg2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_x      (s1_x_reg),
        .in_side   (s1_side_reg),
        .out_valid (lg_valid),
        .out_lg    (lg_out),
        .out_side  (lg_side)
    );

    isa_vcalc u_vcalc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lg_valid),
        .in_lg     (lg_out),
        .in_side   (lg_side),
        .out_valid (vc_valid),
        .out_fr    (vc_fr),
        .out_side  (vc_side)
    );

    isa_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_valid),
        .in_fr     (vc_fr),
        .in_side   (vc_side),
        .out_valid (ex_valid),
        .out_e     (ex_e),
        .out_side  (ex_side)
    );

    isa_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (ex_valid),
        .in_e        (ex_e),
        .in_side     (ex_side),
        .glide_ratio (glide_reg),
        .out_valid   (done),
        .out_speed   (speed_out),
        .out_sat     (saturated)
    );

endmodule

// ----- bench/airspeed_checker.sv -----
`timescale 1ns / 1ps
module airspeed_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    func,
    input  logic [isa_pkg::SPD_W-1:0]     speed_in,
    input  logic signed [15:0]            altitude_m,
    input  logic signed [6:0]             temp_deviation,
    input  logic                          done,
    input  logic [isa_pkg::OUT_W-1:0]     speed_out,
    input  logic                          saturated,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [isa_pkg::GLIDE_W-1:0]   cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            checked
);
    import isa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    logic [GLIDE_W-1:0] glide_reg;
    logic [OUT_W:0]     expected_q[$];

    function automatic longint log2_fixed(input int unsigned x);
        int unsigned       n;
        longint unsigned   m;
        int unsigned       frac;
        n = 0;
        frac = 0;
        if (x == 0)
            return 0;
        while (n < 31 && (x >> (n + 1)) != 0)
            n++;
        m = longint'(x) << (30 - n);
        for (int i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | (32'd1 << i);
            end
        end
        return longint'((longint'(n) << 24) | frac);
    endfunction

    function automatic longint unsigned exp2_fraction(input int unsigned fr);
        longint unsigned y;
        longint unsigned sum;
        longint unsigned term;
        y = (longint'(fr) * longint'(LN2_Q30)) >> 24;
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * y) >> 30) / k;
            sum += term;
        end
        return sum;
    endfunction

    function automatic logic [OUT_W:0] convert_speed(
        input isa_func_t f, input logic [SPD_W-1:0] spd,
        input logic signed [15:0] alt, input logic signed [6:0] dev,
        input logic [GLIDE_W-1:0] glide);
        longint          ap, tropo, tk, lg0, p, v, lim;
        longint unsigned u, x, r, t, den;
        int unsigned     ip, fr;
        logic            sat;
        sat = 1'b0;
        if (f == FUNC_NONE)
            return '0;
        lim = longint'(8) << 24;
        ap = alt < 0 ? 0 : alt;
        tropo = ap <= TROPO_TOP ? ap : TROPO_TOP;
        lg0 = log2_fixed(T0_X2000);
        p = longint'((longint'(EXPO_Q24) *
            longint'(lg0 - log2_fixed(int'(T0_X2000 - LAPSE_X2000 * tropo)))) >> 24);
        if (ap > TROPO_TOP)
            p += longint'((longint'(STRAT_Q40) * longint'(ap - TROPO_TOP)) >> 16);
        tk = T0_X2000 - LAPSE_X2000 * longint'(alt) + DEV_X2000 * longint'(dev);
        v = (p + log2_fixed(int'(tk)) - lg0) / 2;
        if (f == FUNC_IAS)
            v = -v;
        if (v < -lim)
            v = -lim;
        if (v > lim - 1)
            v = lim - 1;
        u = longint'(v + lim);
        ip = int'(u >> 24);
        fr = int'(u & 64'hFFFFFF);
        x = (longint'(spd) * exp2_fraction(fr)) << ip;
        if (f != FUNC_SINK)
            r = (x + (64'd1 << 37)) >> 38;
        else if (glide == 0)
            r = 65536;
        else
        begin
            t = x >> 22;
            den = (longint'(glide) * SINK_DEN) << (16 + FRAC);
            r = (t * longint'(SINK_NUM) + den / 2) / den;
        end
        if (r > 65535)
        begin
            r = 65535;
            sat = 1'b1;
        end
        return {sat, r[15:0]};
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_reg <= GLIDE_RESET;
            errors    <= 0;
            checked   <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                glide_reg <= cfg_data;
            if (start && !busy)
                expected_q.push_back(convert_speed(isa_func_t'(func), speed_in,
                    altitude_m, temp_deviation, glide_reg));
            if (done)
            begin
                checked <= checked + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer speed_out=%0d saturated=%0b",
                        $time, speed_out, saturated);
                    errors <= errors + 1;
                end
                else if (expected_q[0] != {saturated, speed_out})
                begin
                    $display("%0t: mismatch expected %0d/%0b, actual %0d/%0b",
                        $time, expected_q[0][15:0], expected_q[0][16],
                        speed_out, saturated);
                    errors <= errors + 1;
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import isa_pkg::*;

    localparam int LATENCY = 87;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           func;
    logic [SPD_W-1:0]     speed_in;
    logic signed [15:0]   altitude_m;
    logic signed [6:0]    temp_deviation;
    logic                 done;
    logic [OUT_W-1:0]     speed_out;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [GLIDE_W-1:0]   cfg_data;
    int                   errors;
    int                   pending;
    int                   checked;
    int                   idle_pct;
    int                   sent;

    isa_airspeed_converter_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .speed_in(speed_in), .altitude_m(altitude_m), .temp_deviation(temp_deviation),
        .done(done), .speed_out(speed_out), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    airspeed_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .speed_in(speed_in), .altitude_m(altitude_m), .temp_deviation(temp_deviation),
        .done(done), .speed_out(speed_out), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic send_conversion(input isa_func_t f, input logic [SPD_W-1:0] s,
        input logic signed [15:0] a, input logic signed [6:0] d);
        logic b;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start          <= 1'b1;
        func           <= f;
        speed_in       <= s;
        altitude_m     <= a;
        temp_deviation <= d;
        do
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
        end
        while (b);
        sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_glide(input logic [GLIDE_W-1:0] g);
        logic r;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do
        begin
            @(negedge clk);
            r = cfg_ready;
            @(posedge clk);
        end
        while (!r);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        isa_func_t          f;
        logic signed [15:0] a;
        f = isa_func_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
        if ($urandom_range(0, 4) == 0)
            a = 16'($urandom);
        else
            a = 16'($urandom_range(0, 20500)) - 16'sd500;
        send_conversion(f, SPD_W'($urandom), a, 7'($urandom));
    endtask

    logic [GLIDE_W-1:0] glide_plan[6];

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        func           = '0;
        speed_in       = '0;
        altitude_m     = '0;
        temp_deviation = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        idle_pct       = 0;
        sent           = 0;
        glide_plan     = '{6'd1, 6'd63, 6'd0, 6'd37, 6'd15, 6'd7};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_conversion(FUNC_TAS, '0, 16'sd0, 7'sd0);
        send_conversion(FUNC_TAS, '1, 16'sd0, 7'sd0);
        send_conversion(FUNC_IAS, '1, 16'sd20000, 7'sd63);
        send_conversion(FUNC_SINK, '1, 16'sd20000, -7'sd64);
        send_conversion(FUNC_NONE, '1, 16'sd5000, 7'sd10);
        send_conversion(FUNC_TAS, 14'd2000, -16'sd500, -7'sd64);
        send_conversion(FUNC_TAS, 14'd2000, -16'sd32768, 7'sd63);
        send_conversion(FUNC_IAS, 14'd2000, 16'sd32767, -7'sd64);
        send_conversion(FUNC_TAS, 14'd3000, 16'sd11000, 7'sd0);
        send_conversion(FUNC_TAS, 14'd3000, 16'sd11001, 7'sd0);
        send_conversion(FUNC_IAS, 14'd3000, 16'sd10999, 7'sd5);
        send_conversion(FUNC_SINK, 14'd1600, 16'sd0, 7'sd0);
        send_conversion(FUNC_SINK, 14'd1600, 16'sd32767, 7'sd63);
        send_conversion(FUNC_IAS, 14'd1, -16'sd1, -7'sd1);
        send_conversion(FUNC_TAS, 14'h2AAA, 16'sh5555, 7'sh2A);
        send_conversion(FUNC_IAS, 14'h1555, -16'sh5556, 7'sh55);

        for (int seg = 0; seg < 6; seg++)
        begin
            write_glide(glide_plan[seg]);
            if (seg == 2)
                send_conversion(FUNC_SINK, 14'd1600, 16'sd1000, 7'sd0);
            idle_pct = seg < 2 ? 25 : (seg < 4 ? 67 : 0);
            repeat (190) send_random();
        end
        drain_results();

        $display("Sent %0d conversions and checked %0d results over six glide ratio settings.",
            sent, checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
